// File: rtl/print_job_text_scanner_assert.svh
// Assertion macros for the print job text scanner.
`ifndef PRINT_JOB_TEXT_SCANNER_ASSERT_SVH
`define PRINT_JOB_TEXT_SCANNER_ASSERT_SVH

`ifndef SYNTHESIS

// Check that the condition holds at every clock edge outside reset.
`define PJTS_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("pjts assertion failed: invariant violated");

// Check that the consequent holds in the same cycle as the antecedent.
`define PJTS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pjts assertion failed: implication violated");

`else

`define PJTS_ASSERT_ALWAYS(label, clk, rst, cond)
`define PJTS_ASSERT_SAME(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/pjts_pkg.sv
`default_nettype none

package pjts_pkg;

   typedef enum logic [1:0] {
      ST_VALID     = 2'd0,
      ST_BAD_SIG   = 2'd1,
      ST_BAD_BYTE  = 2'd2,
      ST_TRUNCATED = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       text;
      logic       sig_bad;
      logic       last;
   } queue_entry_type;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [3:0] TEXT_START  = 4'd9;
   localparam logic [3:0] SIG_LAST    = 4'd12;
   localparam logic [3:0] UEL_LEN     = 4'd9;
   localparam logic [2:0] PREFIX_LEN  = 3'd4;

   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_ESC = 8'h1B;

   localparam logic [7:0] U8_CONT_LO = 8'h80;
   localparam logic [7:0] U8_CONT_HI = 8'hBF;
   localparam logic [7:0] U8_E0_LO   = 8'hA0;
   localparam logic [7:0] U8_ED_HI   = 8'h9F;
   localparam logic [7:0] U8_F0_LO   = 8'h90;
   localparam logic [7:0] U8_F4_HI   = 8'h8F;

   function automatic logic [7:0] sig_byte(input logic [3:0] idx);
      logic [7:0] b;
      case (idx)
         4'd0:    b = CH_ESC;
         4'd1:    b = 8'h25;
         4'd2:    b = 8'h2D;
         4'd3:    b = 8'h31;
         4'd4:    b = 8'h32;
         4'd5:    b = 8'h33;
         4'd6:    b = 8'h34;
         4'd7:    b = 8'h35;
         4'd8:    b = 8'h58;
         4'd9:    b = 8'h40;
         4'd10:   b = 8'h50;
         4'd11:   b = 8'h4A;
         4'd12:   b = 8'h4C;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// File: rtl/pjts_front.sv
`default_nettype none

module pjts_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [7:0]               req_data_byte,
   input  wire logic                     req_end_of_input,
   input  wire logic                     q_full,
   output logic                          q_push,
   output pjts_pkg::queue_entry_type     q_push_entry
);
   import pjts_pkg::*;

   typedef enum logic [2:0] {
      PH_SIG  = 3'b001,
      PH_TEXT = 3'b010,
      PH_DONE = 3'b100
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [3:0] pos_ff, pos_in;
   logic       accept;
   logic       text;
   logic       sig_bad;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      text     = 1'b0;
      sig_bad  = 1'b0;
      phase_in = phase_ff;
      pos_in   = pos_ff;
      case (phase_ff)
         PH_SIG: begin
            if (req_data_byte != sig_byte(pos_ff)) begin
               sig_bad  = 1'b1;
               phase_in = PH_DONE;
            end else begin
               text = (pos_ff >= TEXT_START);
               if (pos_ff == SIG_LAST) begin
                  phase_in = PH_TEXT;
               end else begin
                  pos_in  = pos_ff + 4'd1;
                  sig_bad = req_end_of_input;
               end
            end
         end
         PH_TEXT: begin
            text = 1'b1;
         end
         PH_DONE: begin
            sig_bad = 1'b1;
         end
         default: begin
            sig_bad  = 1'b1;
            phase_in = PH_DONE;
         end
      endcase
      if (req_end_of_input) begin
         phase_in = PH_SIG;
         pos_in   = 4'd0;
      end
   end

   assign q_push                 = accept && (text || req_end_of_input);
   assign q_push_entry.data_byte = req_data_byte;
   assign q_push_entry.text      = text;
   assign q_push_entry.sig_bad   = sig_bad;
   assign q_push_entry.last      = req_end_of_input;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SIG;
         pos_ff   <= 4'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/pjts_queue.sv
`default_nettype none

module pjts_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire pjts_pkg::queue_entry_type   push_entry,
   output logic                             full,
   input  wire logic                        pop,
   output logic                             pop_valid,
   output pjts_pkg::queue_entry_type        pop_entry
);
   import pjts_pkg::*;

   queue_entry_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/pjts_back.sv
`default_nettype none

module pjts_back #(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        q_valid,
   input  wire pjts_pkg::queue_entry_type   q_entry,
   output logic                             q_pop,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [1:0]                       rsp_status,
   output logic [31:0]                      rsp_text_length,
   output logic [31:0]                      rsp_line_count,
   output logic [31:0]                      rsp_command_count,
   output logic [31:0]                      rsp_uel_count,
   output logic                             rsp_found_terminator,
   output logic                             rsp_all_ascii
);
   import pjts_pkg::*;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   function automatic count_type sat_inc(input count_type v);
      return (&v) ? v : v + COUNT_WIDTH'(1);
   endfunction

   logic       done_ff, done_in;
   status_type held_status_ff, held_status_in;
   logic       held_term_ff, held_term_in;
   logic [1:0] pending_ff, pending_in;
   logic [7:0] low_ff, low_in;
   logic [7:0] high_ff, high_in;
   logic [2:0] prefix_ff, prefix_in;
   logic [3:0] uel_ff, uel_in;
   count_type  lf_ff, lf_in;
   count_type  cmd_ff, cmd_in;
   count_type  uelcnt_ff, uelcnt_in;
   count_type  text_ff, text_in;
   logic [7:0] prev_ff, prev_in;
   logic       ascii_ff, ascii_in;

   logic       out_valid_ff, out_valid_in;
   status_type out_status_ff, out_status_in;
   logic [31:0] out_length_ff, out_length_in;
   logic [31:0] out_lines_ff, out_lines_in;
   logic [31:0] out_cmd_ff, out_cmd_in;
   logic [31:0] out_uel_ff, out_uel_in;
   logic       out_term_ff, out_term_in;
   logic       out_ascii_ff, out_ascii_in;

   logic       take;
   logic       finish;
   logic       counted;
   logic       ok;
   logic [7:0] c;
   count_type  lines;
   status_type status;

   assign c      = q_entry.data_byte;
   assign take   = q_valid && (!q_entry.last || !out_valid_ff || !rsp_stall);
   assign finish = take && q_entry.last;
   assign q_pop  = take;

   always_comb begin
      done_in        = done_ff;
      held_status_in = held_status_ff;
      held_term_in   = held_term_ff;
      pending_in     = pending_ff;
      low_in         = low_ff;
      high_in        = high_ff;
      prefix_in      = prefix_ff;
      uel_in         = uel_ff;
      lf_in          = lf_ff;
      cmd_in         = cmd_ff;
      uelcnt_in      = uelcnt_ff;
      text_in        = text_ff;
      prev_in        = prev_ff;
      ascii_in       = ascii_ff;
      counted        = 1'b0;
      ok             = 1'b1;

      if (take && q_entry.text && !done_ff) begin
         if (c == CH_NUL) begin
            held_term_in   = 1'b1;
            held_status_in = (pending_ff != 2'd0) ? ST_TRUNCATED : ST_VALID;
            done_in        = 1'b1;
         end else begin
            if (pending_ff != 2'd0) begin
               ok = (c >= low_ff) && (c <= high_ff);
               if (ok) begin
                  pending_in = pending_ff - 2'd1;
                  low_in     = U8_CONT_LO;
                  high_in    = U8_CONT_HI;
               end
            end else if (c >= U8_CONT_LO) begin
               low_in  = U8_CONT_LO;
               high_in = U8_CONT_HI;
               case (c) inside
                  [8'hC2:8'hDF]: pending_in = 2'd1;
                  8'hE0: begin
                     pending_in = 2'd2;
                     low_in     = U8_E0_LO;
                  end
                  8'hED: begin
                     pending_in = 2'd2;
                     high_in    = U8_ED_HI;
                  end
                  [8'hE1:8'hEF]: pending_in = 2'd2;
                  8'hF0: begin
                     pending_in = 2'd3;
                     low_in     = U8_F0_LO;
                  end
                  [8'hF1:8'hF3]: pending_in = 2'd3;
                  8'hF4: begin
                     pending_in = 2'd3;
                     high_in    = U8_F4_HI;
                  end
                  default: ok = 1'b0;
               endcase
            end

            if (!ok) begin
               held_status_in = ST_BAD_BYTE;
               done_in        = 1'b1;
            end else begin
               counted = 1'b1;
               text_in = sat_inc(text_ff);
               if (c >= U8_CONT_LO) begin
                  ascii_in = 1'b0;
               end
               if (prefix_ff < PREFIX_LEN) begin
                  if (c == sig_byte(TEXT_START + 4'(prefix_ff))) begin
                     prefix_in = prefix_ff + 3'd1;
                     if (prefix_in == PREFIX_LEN) begin
                        cmd_in = sat_inc(cmd_ff);
                     end
                  end else begin
                     prefix_in = PREFIX_LEN;
                  end
               end
               if (c == CH_LF) begin
                  lf_in     = sat_inc(lf_ff);
                  prefix_in = 3'd0;
               end
               if (c == sig_byte((uel_ff >= UEL_LEN) ? 4'd0 : uel_ff)) begin
                  uel_in = ((uel_ff >= UEL_LEN) ? 4'd0 : uel_ff) + 4'd1;
                  if (uel_in == UEL_LEN) begin
                     uelcnt_in = sat_inc(uelcnt_ff);
                     uel_in    = 4'd0;
                     prefix_in = 3'd0;
                  end
               end else begin
                  uel_in = (c == CH_ESC) ? 4'd1 : 4'd0;
               end
               prev_in = c;
            end
         end
      end

      lines = (counted || prev_ff != CH_LF) ? sat_inc(lf_ff) : lf_ff;

      if (q_entry.sig_bad) begin
         status = ST_BAD_SIG;
      end else if (done_in) begin
         status = held_status_in;
      end else begin
         status = (pending_in != 2'd0) ? ST_TRUNCATED : ST_VALID;
      end

      out_valid_in  = out_valid_ff && rsp_stall;
      out_status_in = out_status_ff;
      out_length_in = out_length_ff;
      out_lines_in  = out_lines_ff;
      out_cmd_in    = out_cmd_ff;
      out_uel_in    = out_uel_ff;
      out_term_in   = out_term_ff;
      out_ascii_in  = out_ascii_ff;
      if (finish) begin
         out_valid_in  = 1'b1;
         out_status_in = status;
         out_length_in = '0;
         out_lines_in  = '0;
         out_cmd_in    = '0;
         out_uel_in    = '0;
         out_term_in   = 1'b0;
         out_ascii_in  = 1'b0;
         if (status == ST_VALID) begin
            out_length_in = 32'(text_in);
            out_lines_in  = 32'(lines);
            out_cmd_in    = 32'(cmd_in);
            out_uel_in    = 32'(uelcnt_in);
            out_term_in   = done_in && held_term_in;
            out_ascii_in  = ascii_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || finish) begin
         done_ff        <= 1'b0;
         held_status_ff <= ST_VALID;
         held_term_ff   <= 1'b0;
         pending_ff     <= 2'd0;
         low_ff         <= 8'h00;
         high_ff        <= 8'h00;
         prefix_ff      <= 3'd0;
         uel_ff         <= 4'd0;
         lf_ff          <= '0;
         cmd_ff         <= '0;
         uelcnt_ff      <= '0;
         text_ff        <= '0;
         prev_ff        <= 8'h00;
         ascii_ff       <= 1'b1;
      end else begin
         done_ff        <= done_in;
         held_status_ff <= held_status_in;
         held_term_ff   <= held_term_in;
         pending_ff     <= pending_in;
         low_ff         <= low_in;
         high_ff        <= high_in;
         prefix_ff      <= prefix_in;
         uel_ff         <= uel_in;
         lf_ff          <= lf_in;
         cmd_ff         <= cmd_in;
         uelcnt_ff      <= uelcnt_in;
         text_ff        <= text_in;
         prev_ff        <= prev_in;
         ascii_ff       <= ascii_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_length_ff <= out_length_in;
      out_lines_ff  <= out_lines_in;
      out_cmd_ff    <= out_cmd_in;
      out_uel_ff    <= out_uel_in;
      out_term_ff   <= out_term_in;
      out_ascii_ff  <= out_ascii_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_status           = out_status_ff;
   assign rsp_text_length      = out_length_ff;
   assign rsp_line_count       = out_lines_ff;
   assign rsp_command_count    = out_cmd_ff;
   assign rsp_uel_count        = out_uel_ff;
   assign rsp_found_terminator = out_term_ff;
   assign rsp_all_ascii        = out_ascii_ff;

endmodule

`default_nettype wire

// File: rtl/print_job_text_scanner.sv
// Print job text scanner: takes one byte of a print job per request, checks
// the ESC "%-12345X@PJL" signature, validates the text from offset 9 on as
// strict UTF-8 and counts lines, @PJL commands and UEL sequences. It sustains
// one request per cycle while req_stall is low; the front stage classifies
// each byte and feeds a four-entry queue, and the back stage updates the
// scan state and registers the result once the end_of_input request leaves
// the queue. While rsp_stall holds a result, text bytes keep flowing into the
// back stage and the next end-of-job byte waits at the head of the queue;
// req_stall rises once the queue is full. Counters are COUNT_WIDTH bits and
// saturate; the 32-bit result fields carry their low bits.
`default_nettype none

`include "print_job_text_scanner_assert.svh"

module print_job_text_scanner #(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_input,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_text_length,
   output logic [31:0]      rsp_line_count,
   output logic [31:0]      rsp_command_count,
   output logic [31:0]      rsp_uel_count,
   output logic             rsp_found_terminator,
   output logic             rsp_all_ascii
);
   import pjts_pkg::*;

   logic            q_push;
   logic            q_full;
   logic            q_pop;
   logic            q_valid;
   queue_entry_type q_push_entry;
   queue_entry_type q_entry;

   pjts_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_end_of_input (req_end_of_input),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_push_entry     (q_push_entry)
   );

   pjts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (q_entry)
   );

   pjts_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .q_valid              (q_valid),
      .q_entry              (q_entry),
      .q_pop                (q_pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_text_length      (rsp_text_length),
      .rsp_line_count       (rsp_line_count),
      .rsp_command_count    (rsp_command_count),
      .rsp_uel_count        (rsp_uel_count),
      .rsp_found_terminator (rsp_found_terminator),
      .rsp_all_ascii        (rsp_all_ascii)
   );

   `PJTS_ASSERT_ALWAYS(a_no_push_when_full, clock, reset, !(q_push && q_full))
   `PJTS_ASSERT_SAME(a_rsp_from_last, clock, reset, $rose(rsp_valid),
      $past(q_pop && q_entry.last))
   `PJTS_ASSERT_SAME(a_fail_fields_zero, clock, reset,
      rsp_valid && (rsp_status != ST_VALID),
      (rsp_text_length == 32'd0) && (rsp_line_count == 32'd0) &&
      (rsp_command_count == 32'd0) && (rsp_uel_count == 32'd0) &&
      !rsp_found_terminator && !rsp_all_ascii)

endmodule

`default_nettype wire

// File: bench/job_summary_checker.sv
`timescale 1ns / 1ps

module job_summary_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_input,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [1:0]  rsp_status,
   input  wire logic [31:0] rsp_text_length,
   input  wire logic [31:0] rsp_line_count,
   input  wire logic [31:0] rsp_command_count,
   input  wire logic [31:0] rsp_uel_count,
   input  wire logic        rsp_found_terminator,
   input  wire logic        rsp_all_ascii,
   output int               mismatches,
   output int               pending,
   output int               summaries_checked
);
   import pjts_pkg::*;

   typedef enum logic [2:0] {
      SCAN_SIG  = 3'b001,
      SCAN_TEXT = 3'b010,
      SCAN_DONE = 3'b100
   } scan_phase_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] text_length;
      logic [31:0] line_count;
      logic [31:0] command_count;
      logic [31:0] uel_count;
      logic        found_terminator;
      logic        all_ascii;
   } job_summary_type;

   localparam logic [0:12][7:0] JOB_HEADER = {
      8'h1B, 8'h25, 8'h2D, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h58,
      8'h40, 8'h50, 8'h4A, 8'h4C
   };
   localparam logic [2:0] NO_PREFIX = 3'd4;

   scan_phase_type  scan_phase;
   logic [3:0]      sig_pos;
   logic [1:0]      u8_need;
   logic [7:0]      u8_lo;
   logic [7:0]      u8_hi;
   logic [2:0]      cmd_match;
   logic [3:0]      uel_pos;
   logic [31:0]     lf_n;
   logic [31:0]     cmd_n;
   logic [31:0]     uel_n;
   logic [31:0]     text_n;
   logic [7:0]      last_byte;
   logic            no_high;
   status_type      held_st;
   logic            held_nul;
   job_summary_type expected_summaries[$];
   int              mismatch_total = 0;
   int              checked_total = 0;

   function automatic logic [31:0] bump(input logic [31:0] v);
      return (&v) ? v : v + 32'd1;
   endfunction

   function void clear_scan();
      scan_phase = SCAN_SIG;
      sig_pos    = '0;
      u8_need    = '0;
      u8_lo      = '0;
      u8_hi      = '0;
      cmd_match  = '0;
      uel_pos    = '0;
      lf_n       = '0;
      cmd_n      = '0;
      uel_n      = '0;
      text_n     = '0;
      last_byte  = '0;
      no_high    = 1'b1;
      held_st    = ST_VALID;
      held_nul   = 1'b0;
   endfunction

   function logic utf8_take(input logic [7:0] c);
      if (u8_need != 0) begin
         if (c < u8_lo || c > u8_hi) return 1'b0;
         u8_need = u8_need - 2'd1;
         u8_lo   = U8_CONT_LO;
         u8_hi   = U8_CONT_HI;
         return 1'b1;
      end
      if (c < 8'h80) return 1'b1;
      u8_lo = U8_CONT_LO;
      u8_hi = U8_CONT_HI;
      if (c >= 8'hC2 && c <= 8'hDF) begin
         u8_need = 2'd1;
      end else if (c == 8'hE0) begin
         u8_need = 2'd2;
         u8_lo   = U8_E0_LO;
      end else if (c == 8'hED) begin
         u8_need = 2'd2;
         u8_hi   = U8_ED_HI;
      end else if (c >= 8'hE1 && c <= 8'hEF) begin
         u8_need = 2'd2;
      end else if (c == 8'hF0) begin
         u8_need = 2'd3;
         u8_lo   = U8_F0_LO;
      end else if (c >= 8'hF1 && c <= 8'hF3) begin
         u8_need = 2'd3;
      end else if (c == 8'hF4) begin
         u8_need = 2'd3;
         u8_hi   = U8_F4_HI;
      end else begin
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function void tally(input logic [7:0] c);
      if (c >= 8'h80) no_high = 1'b0;
      if (cmd_match < NO_PREFIX) begin
         if (c == JOB_HEADER[9 + cmd_match]) begin
            cmd_match = cmd_match + 3'd1;
            if (cmd_match == NO_PREFIX) cmd_n = bump(cmd_n);
         end else begin
            cmd_match = NO_PREFIX;
         end
      end
      if (c == CH_LF) begin
         lf_n      = bump(lf_n);
         cmd_match = '0;
      end
      if (c == JOB_HEADER[uel_pos]) begin
         uel_pos = uel_pos + 4'd1;
         if (uel_pos == UEL_LEN) begin
            uel_n     = bump(uel_n);
            uel_pos   = '0;
            cmd_match = '0;
         end
      end else begin
         uel_pos = (c == CH_ESC) ? 4'd1 : 4'd0;
      end
      last_byte = c;
   endfunction

   function void text_step(input logic [7:0] c);
      if (c == CH_NUL) begin
         held_nul   = 1'b1;
         held_st    = (u8_need != 0) ? ST_TRUNCATED : ST_VALID;
         scan_phase = SCAN_DONE;
      end else if (!utf8_take(c)) begin
         held_st    = ST_BAD_BYTE;
         scan_phase = SCAN_DONE;
      end else begin
         tally(c);
         text_n = bump(text_n);
      end
   endfunction

   function void scan_job_byte(input logic [7:0] c, input logic eoi);
      job_summary_type s;
      status_type      st;
      logic            nul;
      nul = 1'b0;
      case (scan_phase)
         SCAN_SIG: begin
            if (sig_pos > SIG_LAST || c != JOB_HEADER[sig_pos]) begin
               held_st    = ST_BAD_SIG;
               scan_phase = SCAN_DONE;
            end else begin
               if (sig_pos >= TEXT_START) text_step(c);
               if (sig_pos == SIG_LAST) scan_phase = SCAN_TEXT;
               else sig_pos = sig_pos + 4'd1;
            end
         end
         SCAN_TEXT: text_step(c);
         default: ;
      endcase
      if (!eoi) return;
      case (scan_phase)
         SCAN_SIG:  st = ST_BAD_SIG;
         SCAN_TEXT: st = (u8_need != 0) ? ST_TRUNCATED : ST_VALID;
         default: begin
            st  = held_st;
            nul = held_nul;
         end
      endcase
      s        = '0;
      s.status = st;
      if (st == ST_VALID) begin
         s.text_length      = text_n;
         s.line_count       = (last_byte != CH_LF) ? bump(lf_n) : lf_n;
         s.command_count    = cmd_n;
         s.uel_count        = uel_n;
         s.found_terminator = nul;
         s.all_ascii        = no_high;
      end
      expected_summaries.push_back(s);
      clear_scan();
   endfunction

   function string show(input job_summary_type s);
      return $sformatf("status=%0d len=%0d lines=%0d cmds=%0d uels=%0d nul=%0b ascii=%0b",
                       s.status, s.text_length, s.line_count, s.command_count,
                       s.uel_count, s.found_terminator, s.all_ascii);
   endfunction

   function void note_mismatch(input string what);
      mismatch_total++;
      if (mismatch_total <= 10) $display("%0t ns: %s", $time, what);
   endfunction

   function void check_summary();
      job_summary_type got;
      job_summary_type want;
      got.status           = status_type'(rsp_status);
      got.text_length      = rsp_text_length;
      got.line_count       = rsp_line_count;
      got.command_count    = rsp_command_count;
      got.uel_count        = rsp_uel_count;
      got.found_terminator = rsp_found_terminator;
      got.all_ascii        = rsp_all_ascii;
      if (expected_summaries.size() == 0) begin
         note_mismatch({"result with no job pending: ", show(got)});
         return;
      end
      want = expected_summaries.pop_front();
      checked_total++;
      if (got !== want)
         note_mismatch({"expected ", show(want), " got ", show(got)});
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_scan();
         expected_summaries.delete();
      end else begin
         if (req_valid && !req_stall) scan_job_byte(req_data_byte, req_end_of_input);
         if (rsp_valid && !rsp_stall) check_summary();
      end
      mismatches        <= mismatch_total;
      pending           <= expected_summaries.size();
      summaries_checked <= checked_total;
   end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

   import pjts_pkg::*;

   localparam int RUN_LIMIT   = 300000;
   localparam int BYTE_TARGET = 1800;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_end_of_input = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_text_length;
   logic [31:0] rsp_line_count;
   logic [31:0] rsp_command_count;
   logic [31:0] rsp_uel_count;
   logic        rsp_found_terminator;
   logic        rsp_all_ascii;

   int          mismatches;
   int          pending;
   int          summaries_checked;
   logic        quiet = 1'b0;
   int          cycle_count = 0;
   int          bytes_sent = 0;
   int          jobs_formed = 0;
   int          jobs_noise = 0;
   logic [7:0]  job_q[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   print_job_text_scanner u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_byte        (req_data_byte),
      .req_end_of_input     (req_end_of_input),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_text_length      (rsp_text_length),
      .rsp_line_count       (rsp_line_count),
      .rsp_command_count    (rsp_command_count),
      .rsp_uel_count        (rsp_uel_count),
      .rsp_found_terminator (rsp_found_terminator),
      .rsp_all_ascii        (rsp_all_ascii)
   );

   job_summary_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_byte        (req_data_byte),
      .req_end_of_input     (req_end_of_input),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_text_length      (rsp_text_length),
      .rsp_line_count       (rsp_line_count),
      .rsp_command_count    (rsp_command_count),
      .rsp_uel_count        (rsp_uel_count),
      .rsp_found_terminator (rsp_found_terminator),
      .rsp_all_ascii        (rsp_all_ascii),
      .mismatches           (mismatches),
      .pending              (pending),
      .summaries_checked    (summaries_checked)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_stall   <= !reset && !quiet && ($urandom_range(99) < 22);
      if (cycle_count == RUN_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function logic gap_now();
      return !quiet && ($urandom_range(99) < 22);
   endfunction

   task send_byte(input logic [7:0] b, input logic eoi);
      while (gap_now()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= b;
      req_end_of_input <= eoi;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task send_job();
      foreach (job_q[i]) send_byte(job_q[i], i == job_q.size() - 1);
      job_q.delete();
   endtask

   // hold the sender until every pending summary has come back
   task drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function void push_rand(input int lo, input int hi);
      job_q.push_back(8'($urandom_range(hi, lo)));
   endfunction

   function void add_header(input int count);
      for (int i = 0; i < count; i++) job_q.push_back(sig_byte(4'(i)));
   endfunction

   function void add_utf8_char();
      logic [7:0] lead;
      case ($urandom_range(4, 2))
         2: begin
            push_rand(8'hC2, 8'hDF);
            push_rand(8'h80, 8'hBF);
         end
         3: begin
            lead = 8'($urandom_range(8'hEF, 8'hE0));
            job_q.push_back(lead);
            if (lead == 8'hE0) push_rand(8'hA0, 8'hBF);
            else if (lead == 8'hED) push_rand(8'h80, 8'h9F);
            else push_rand(8'h80, 8'hBF);
            push_rand(8'h80, 8'hBF);
         end
         default: begin
            lead = 8'($urandom_range(8'hF4, 8'hF0));
            job_q.push_back(lead);
            if (lead == 8'hF0) push_rand(8'h90, 8'hBF);
            else if (lead == 8'hF4) push_rand(8'h80, 8'h8F);
            else push_rand(8'h80, 8'hBF);
            push_rand(8'h80, 8'hBF);
            push_rand(8'h80, 8'hBF);
         end
      endcase
   endfunction

   function void add_bad_byte();
      case ($urandom_range(5, 0))
         0: push_rand(8'h80, 8'hC1);
         1: push_rand(8'hF5, 8'hFF);
         2: begin
            job_q.push_back(8'hE0);
            push_rand(8'h80, 8'h9F);
         end
         3: begin
            job_q.push_back(8'hED);
            push_rand(8'hA0, 8'hBF);
         end
         4: begin
            job_q.push_back(8'hF0);
            push_rand(8'h80, 8'h8F);
         end
         default: begin
            job_q.push_back(8'hF4);
            push_rand(8'h90, 8'hFF);
         end
      endcase
   endfunction

   function void add_text_token();
      int n;
      case ($urandom_range(11, 0))
         0, 1, 2, 3: push_rand(8'h01, 8'h7F);
         4, 5: job_q.push_back(CH_LF);
         6: for (int i = 9; i < 13; i++) job_q.push_back(sig_byte(4'(i)));
         7: add_header(9);
         8: add_utf8_char();
         9: add_header($urandom_range(8, 1));
         10: begin
            n = $urandom_range(3, 1);
            for (int i = 0; i < n; i++) job_q.push_back(sig_byte(4'(9 + i)));
         end
         default: job_q.push_back(CH_ESC);
      endcase
   endfunction

   function void build_structured();
      int n;
      add_header(13);
      n = ($urandom_range(19) == 0) ? $urandom_range(80, 30) : $urandom_range(14, 0);
      repeat (n) add_text_token();
      case ($urandom_range(9, 0))
         0: begin
            job_q.push_back(CH_NUL);
            repeat ($urandom_range(3, 0)) push_rand(0, 255);
         end
         1: begin
            add_bad_byte();
            repeat ($urandom_range(3, 0)) push_rand(0, 255);
         end
         2: begin
            push_rand(8'hC2, 8'hF4);
            if ($urandom_range(1)) job_q.push_back(CH_NUL);
         end
         default: ;
      endcase
   endfunction

   function void build_noise();
      int k;
      case ($urandom_range(2, 0))
         0: repeat ($urandom_range(20, 1)) push_rand(0, 255);
         1: add_header($urandom_range(12, 1));
         default: begin
            add_header(13);
            k = $urandom_range(12, 0);
            job_q[k] = job_q[k] ^ 8'($urandom_range(255, 1));
            repeat ($urandom_range(6, 0)) push_rand(0, 255);
         end
      endcase
   endfunction

   initial begin
      int job_index;
      job_index = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      job_q.push_back(8'hFF);
      send_job();
      job_q.push_back(8'h00);
      send_job();
      add_header(2);
      send_job();
      add_header(13);
      job_q.push_back(8'hF4);
      send_job();
      drain();

      while (bytes_sent < BYTE_TARGET) begin
         job_index++;
         quiet = (job_index >= 20 && job_index < 32);
         if ($urandom_range(99) < 80) begin
            build_structured();
            jobs_formed++;
         end else begin
            build_noise();
            jobs_noise++;
         end
         send_job();
         if (job_index % 16 == 0) drain();
      end
      quiet = 1'b0;
      drain();
      repeat (8) @(posedge clock);

      $display("Sent %0d bytes in %0d random jobs (%0d structured, %0d noise or broken)",
               bytes_sent, jobs_formed + jobs_noise, jobs_formed, jobs_noise);
      $display("Compared %0d job summaries, including short, bad signature and truncated jobs",
               summaries_checked);
      if (mismatches == 0 && pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/pjts_pkg.sv
rtl/pjts_front.sv
rtl/pjts_queue.sv
rtl/pjts_back.sv
rtl/print_job_text_scanner.sv
bench/job_summary_checker.sv
bench/testbench.sv
